// ----- design/region_address_translator_macros.svh -----
// Assertion macros used by the region address translator back end.
`ifndef REGION_ADDRESS_TRANSLATOR_MACROS_SVH
`define REGION_ADDRESS_TRANSLATOR_MACROS_SVH

// Condition and check in the same cycle.
`define RAT_ASSERT_SAME(name, clk, rst, cond, chk, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
      else $error(msg);

// Check holds in the cycle after the condition.
`define RAT_ASSERT_NEXT(name, clk, rst, cond, chk, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
      else $error(msg);

`endif

// ----- design/rat_pkg.sv -----
// Shared types and constants of the region address translator.
package rat_pkg;

   localparam int ADDR_W          = 32;
   localparam int SIZE_W          = 13;
   localparam int ENTRY_INDEX_W   = 3;
   localparam int OP_W            = 2;
   localparam int MB_SHIFT        = 20;   // one megabyte = 0x100000 bytes
   localparam int END_W           = SIZE_W + MB_SHIFT + 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int REGION_COUNT_DEF = 8;

   // Request op codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_V2P   = 2'd1;
   localparam logic [OP_W-1:0] OP_P2V   = 2'd2;

   // Command kinds handed from front to back
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_V2P   = 2'd1;
   localparam logic [1:0] CMD_P2V   = 2'd2;
   localparam logic [1:0] CMD_PASS  = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic                     entry_valid;
      logic [ADDR_W-1:0]        phys_base;
      logic [ADDR_W-1:0]        virt_base;
      logic [SIZE_W-1:0]        size_mb;
      logic                     cacheable;
      logic [ADDR_W-1:0]        address;
      logic                     want_cached;
   } cmd_type;

endpackage

// ----- design/rat_front.sv -----
// Front end: accepts request transactions and classifies them into commands.
module rat_front import rat_pkg::*; #(
   parameter int REGION_COUNT = REGION_COUNT_DEF
) (
   input  logic                     push,
   output logic                     full,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic                     req_entry_valid,
   input  logic [ADDR_W-1:0]        req_entry_phys_base,
   input  logic [ADDR_W-1:0]        req_entry_virt_base,
   input  logic [SIZE_W-1:0]        req_entry_size_mb,
   input  logic                     req_entry_cacheable,
   input  logic [ADDR_W-1:0]        req_lookup_address,
   input  logic                     req_want_cached,
   input  logic                     translation_enabled,
   input  logic                     q_full,
   output logic                     q_push,
   output cmd_type                  q_data
);

   logic       keep;
   logic       index_ok;
   logic [1:0] kind;

   assign index_ok = (int'(req_entry_index) < REGION_COUNT);

   always_comb begin
      keep = 1'b0;
      kind = CMD_WRITE;
      case (req_op)
         OP_WRITE: begin
            keep = index_ok;
            kind = CMD_WRITE;
         end
         OP_V2P: begin
            keep = 1'b1;
            kind = CMD_V2P;
         end
         OP_P2V: begin
            keep = 1'b1;
            // disabled translation turns the lookup into a passthrough
            kind = translation_enabled ? CMD_P2V : CMD_PASS;
         end
         default: begin
            keep = 1'b0;
            kind = CMD_WRITE;
         end
      endcase
   end

   assign q_data.kind        = kind;
   assign q_data.entry_index = req_entry_index;
   assign q_data.entry_valid = req_entry_valid;
   assign q_data.phys_base   = req_entry_phys_base;
   assign q_data.virt_base   = req_entry_virt_base;
   assign q_data.size_mb     = req_entry_size_mb;
   assign q_data.cacheable   = req_entry_cacheable;
   assign q_data.address     = req_lookup_address;
   assign q_data.want_cached = req_want_cached;

   // dropped transactions are still accepted, they just never reach the queue
   assign full   = q_full;
   assign q_push = push && !q_full && keep;

endmodule

// ----- design/rat_queue.sv -----
// Short command queue between front and back ends.
module rat_queue import rat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_push,
   input  cmd_type q_wdata,
   output logic    q_full,
   input  logic    q_pop,
   output cmd_type q_head,
   output logic    q_empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entries_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// ----- design/rat_back.sv -----
// Back end: region table, sequential region walk and result register.
`include "region_address_translator_macros.svh"

module rat_back import rat_pkg::*; #(
   parameter int REGION_COUNT = REGION_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           q_head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [ADDR_W-1:0] rsp_translated_address,
   output logic              rsp_hit
);

   localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // region table
   logic [ADDR_W-1:0]       phys_base_ff [REGION_COUNT];
   logic [ADDR_W-1:0]       virt_base_ff [REGION_COUNT];
   logic [SIZE_W-1:0]       size_mb_ff   [REGION_COUNT];
   logic [REGION_COUNT-1:0] cacheable_ff;
   logic [REGION_COUNT-1:0] in_use_ff, in_use_in;
   logic                    tbl_we;
   logic [IDX_W-1:0]        wr_idx;

   // walk control
   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  walk_idx_ff, walk_idx_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic              cur_from_phys_ff, cur_from_phys_in;
   logic              cur_want_ff, cur_want_in;
   logic [ADDR_W-1:0] hit_src_ff, hit_src_in;
   logic [ADDR_W-1:0] hit_dst_ff, hit_dst_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              out_hit_ff, out_hit_in;
   logic              out_free;

   // one region examined per cycle
   logic [ADDR_W-1:0] src, dst;
   logic [END_W-1:0]  win_end;
   logic              in_window, cache_ok, match;

   assign wr_idx = IDX_W'(q_head.entry_index);

   assign src = cur_from_phys_ff ? phys_base_ff[walk_idx_ff] : virt_base_ff[walk_idx_ff];
   assign dst = cur_from_phys_ff ? virt_base_ff[walk_idx_ff] : phys_base_ff[walk_idx_ff];
   // upper bound kept wide so it never wraps
   assign win_end   = END_W'(src) + (END_W'(size_mb_ff[walk_idx_ff]) << MB_SHIFT);
   assign in_window = (cur_addr_ff >= src) && (END_W'(cur_addr_ff) < win_end);
   assign cache_ok  = !cur_from_phys_ff || (cacheable_ff[walk_idx_ff] == cur_want_ff);
   assign match     = in_use_ff[walk_idx_ff] && cache_ok && in_window;

   assign out_free = !out_valid_ff || pop;

   always_comb begin
      state_in         = state_ff;
      walk_idx_in      = walk_idx_ff;
      found_in         = found_ff;
      cur_addr_in      = cur_addr_ff;
      cur_from_phys_in = cur_from_phys_ff;
      cur_want_in      = cur_want_ff;
      hit_src_in       = hit_src_ff;
      hit_dst_in       = hit_dst_ff;
      out_valid_in     = out_valid_ff && !pop;
      out_addr_in      = out_addr_ff;
      out_hit_in       = out_hit_ff;
      in_use_in        = in_use_ff;
      q_pop            = 1'b0;
      tbl_we           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  CMD_WRITE: begin
                     q_pop             = 1'b1;
                     tbl_we            = 1'b1;
                     in_use_in[wr_idx] = q_head.entry_valid;
                  end
                  CMD_PASS: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_valid_in = 1'b1;
                        out_addr_in  = q_head.address;
                        out_hit_in   = 1'b1;
                     end
                  end
                  default: begin
                     q_pop            = 1'b1;
                     cur_addr_in      = q_head.address;
                     cur_from_phys_in = (q_head.kind == CMD_P2V);
                     cur_want_in      = q_head.want_cached;
                     walk_idx_in      = '0;
                     found_in         = 1'b0;
                     state_in         = ST_WALK;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (match) begin
               found_in   = 1'b1;
               hit_src_in = src;
               hit_dst_in = dst;
               state_in   = ST_FINISH;
            end else if (walk_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_hit_in   = found_ff;
               out_addr_in  = found_ff ? (cur_addr_ff - hit_src_ff + hit_dst_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         in_use_ff    <= '0;
         found_ff     <= 1'b0;
         walk_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         in_use_ff    <= in_use_in;
         found_ff     <= found_in;
         walk_idx_ff  <= walk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_addr_ff      <= cur_addr_in;
      cur_from_phys_ff <= cur_from_phys_in;
      cur_want_ff      <= cur_want_in;
      hit_src_ff       <= hit_src_in;
      hit_dst_ff       <= hit_dst_in;
      out_addr_ff      <= out_addr_in;
      out_hit_ff       <= out_hit_in;
      if (tbl_we) begin
         phys_base_ff[wr_idx] <= q_head.phys_base;
         virt_base_ff[wr_idx] <= q_head.virt_base;
         size_mb_ff[wr_idx]   <= q_head.size_mb;
         cacheable_ff[wr_idx] <= q_head.cacheable;
      end
   end

   assign empty                  = !out_valid_ff;
   assign rsp_translated_address = out_addr_ff;
   assign rsp_hit                = out_hit_ff;

   `RAT_ASSERT_SAME(a_miss_zero, clock, reset, out_valid_ff && !out_hit_ff, out_addr_ff == '0, "miss with nonzero address")
   `RAT_ASSERT_SAME(a_pop_in_idle, clock, reset, q_pop, state_ff == ST_IDLE, "queue popped outside idle")
   `RAT_ASSERT_NEXT(a_finish_loads, clock, reset, state_ff == ST_FINISH && out_free, out_valid_ff && state_ff == ST_IDLE, "finish did not load result")
   `RAT_ASSERT_NEXT(a_walk_start, clock, reset, state_ff == ST_IDLE && q_pop && (q_head.kind == CMD_V2P || q_head.kind == CMD_P2V), state_ff == ST_WALK && walk_idx_ff == '0, "walk did not start at slot zero")

endmodule

// ----- design/region_address_translator.sv -----
// Region address translator top level: a table of memory regions with virtual/physical lookup.
//
// Translates addresses through a table of REGION_COUNT regions (base, size in MB,
// cacheable mark, in-use bit). Request transactions enter through push/full and are
// classified by the front end into table writes, lookups or passthroughs, then queued
// (two entries) for the back end. The back end owns the table and one window
// comparator that examines one region per cycle, lowest slot first, stopping at the
// first hit. In the back end a table write is done on dequeue, a physical-to-virtual
// request with translation disabled goes straight to the output register on dequeue,
// and a lookup passes through the dequeue, walk and finish states, the walk visiting
// up to REGION_COUNT regions through the single comparator. Results wait in an
// output register (empty/pop); the back end keeps walking the next lookup while a
// result waits, and the front end keeps accepting while the queue has room. Op 3 and
// writes to a slot at or above REGION_COUNT are accepted and dropped. csr_write_data
// bit 0 is translation_enabled: only write it with no transaction outstanding.
module region_address_translator import rat_pkg::*; #(
   parameter int REGION_COUNT = REGION_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   // request side
   input  logic                     push,
   output logic                     full,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic                     req_entry_valid,
   input  logic [ADDR_W-1:0]        req_entry_phys_base,
   input  logic [ADDR_W-1:0]        req_entry_virt_base,
   input  logic [SIZE_W-1:0]        req_entry_size_mb,
   input  logic                     req_entry_cacheable,
   input  logic [ADDR_W-1:0]        req_lookup_address,
   input  logic                     req_want_cached,
   // response side
   output logic                     empty,
   input  logic                     pop,
   output logic [ADDR_W-1:0]        rsp_translated_address,
   output logic                     rsp_hit
);

   logic    translation_enabled_ff, translation_enabled_in;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_wdata, q_head;

   // translation enable register, resets to disabled
   assign translation_enabled_in = csr_write_enable ? csr_write_data : translation_enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         translation_enabled_ff <= 1'b0;
      end else begin
         translation_enabled_ff <= translation_enabled_in;
      end
   end

   // classify incoming transactions
   rat_front #(
      .REGION_COUNT (REGION_COUNT)
   ) u_front (
      .push                (push),
      .full                (full),
      .req_op              (req_op),
      .req_entry_index     (req_entry_index),
      .req_entry_valid     (req_entry_valid),
      .req_entry_phys_base (req_entry_phys_base),
      .req_entry_virt_base (req_entry_virt_base),
      .req_entry_size_mb   (req_entry_size_mb),
      .req_entry_cacheable (req_entry_cacheable),
      .req_lookup_address  (req_lookup_address),
      .req_want_cached     (req_want_cached),
      .translation_enabled (translation_enabled_ff),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_data              (q_wdata)
   );

   // decouples accept from the walk
   rat_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_empty (q_empty)
   );

   // table, walk and result register
   rat_back #(
      .REGION_COUNT (REGION_COUNT)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_head                 (q_head),
      .q_empty                (q_empty),
      .q_pop                  (q_pop),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_translated_address (rsp_translated_address),
      .rsp_hit                (rsp_hit)
   );

endmodule
